>>> rtl/rob_pkg.sv
package rob_pkg;

    // field widths fixed by the item format
    localparam int POS_W   = 11;
    localparam int RECT_W  = 10;
    localparam int PIX_W   = 8;
    localparam int ROP_W   = 32;
    localparam int CMD_W   = 2;
    // signed coordinate width that holds a position plus a rectangle size
    localparam int CW      = 12;

    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 200;

    typedef enum logic [CMD_W-1:0] {
        CMD_BLIT   = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_SOURCE = 2'd2,
        CMD_READ   = 2'd3
    } rob_cmd_code_t;

    localparam logic [ROP_W-1:0] ROP_BLACKNESS = 32'h0000_0042;
    localparam logic [ROP_W-1:0] ROP_WHITENESS = 32'h00FF_0062;
    localparam logic [ROP_W-1:0] ROP_DSTINVERT = 32'h0055_0009;

    localparam logic [7:0] FILL_BLACK = 8'h42;
    localparam logic [7:0] FILL_WHITE = 8'h62;
    localparam logic [7:0] FILL_COLOR = 8'h21;
    localparam logic [7:0] FILL_XOR   = 8'h09;

    localparam logic [PIX_W-1:0] WHITE_INDEX = 8'd15;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic clr_we;
        logic paint_re;
        logic paint_we;
        logic out_load;
    } rob_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic dec_read;
        logic dec_paint;
        logic dec_rmw;
        logic paint_last;
        logic out_free;
    } rob_stat_t;

endpackage

>>> rtl/rob_frame_ram.sv
module rob_frame_ram #(
    parameter int DEPTH = 64000,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic                      re,
    input  logic [AW-1:0]             addr,
    input  logic [rob_pkg::PIX_W-1:0] wdata,
    output logic [rob_pkg::PIX_W-1:0] rdata
);
    import rob_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

>>> rtl/rob_ctrl.sv
module rob_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rob_pkg::rob_stat_t stat,
    output rob_pkg::rob_ctrl_t ctrl
);
    import rob_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR   = 6'b000001,
        S_IDLE    = 6'b000010,
        S_PAINT   = 6'b000100,
        S_RMW_RD  = 6'b001000,
        S_RMW_WR  = 6'b010000,
        S_RD_WAIT = 6'b100000
    } rob_state_t;

    rob_state_t state_reg, state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        ctrl          = '0;
        ctrl.accept   = accept;
        case (state_reg)
            S_CLEAR:
            begin
                ctrl.clr_we = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (stat.dec_read)
                    begin
                        state_next = S_RD_WAIT;
                    end
                    else if (stat.dec_paint)
                    begin
                        state_next = stat.dec_rmw ? S_RMW_RD : S_PAINT;
                    end
                end
            end
            S_PAINT:
            begin
                ctrl.paint_we = 1'b1;
                if (stat.paint_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RMW_RD:
            begin
                ctrl.paint_re = 1'b1;
                state_next    = S_RMW_WR;
            end
            S_RMW_WR:
            begin
                ctrl.paint_we = 1'b1;
                state_next    = stat.paint_last ? S_IDLE : S_RMW_RD;
            end
            S_RD_WAIT:
            begin
                // read data stays in the RAM output latch until the result slot frees
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/rob_datapath.sv
module rob_datapath #(
    parameter int SCREEN_WIDTH  = rob_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = rob_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rob_pkg::rob_ctrl_t                ctrl,
    output rob_pkg::rob_stat_t                stat,
    input  logic [rob_pkg::CMD_W-1:0]         command,
    input  logic signed [rob_pkg::POS_W-1:0]  pos_x,
    input  logic signed [rob_pkg::POS_W-1:0]  pos_y,
    input  logic [rob_pkg::RECT_W-1:0]        rect_width,
    input  logic [rob_pkg::RECT_W-1:0]        rect_height,
    input  logic [rob_pkg::PIX_W-1:0]         fill_color,
    input  logic [rob_pkg::ROP_W-1:0]         raster_op,
    input  logic [rob_pkg::PIX_W-1:0]         source_pixel,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rob_pkg::PIX_W-1:0]         pixel_value
);
    import rob_pkg::*;

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int YW    = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam logic signed [CW-1:0] SW_S = CW'(SCREEN_WIDTH);
    localparam logic signed [CW-1:0] SH_S = CW'(SCREEN_HEIGHT);
    localparam logic [AW-1:0] LAST_ADDR   = AW'(DEPTH - 1);

    // input decode
    logic cmd_blit, cmd_fill, cmd_src, cmd_read;
    logic op_black, op_white, op_inv, blit_copy;
    logic [7:0] op_low;
    logic       dec_rmw, dec_inv;
    logic [PIX_W-1:0] dec_value;

    assign cmd_blit = (command == CMD_BLIT);
    assign cmd_fill = (command == CMD_FILL);
    assign cmd_src  = (command == CMD_SOURCE);
    assign cmd_read = (command == CMD_READ);
    assign op_black = (raster_op == ROP_BLACKNESS);
    assign op_white = (raster_op == ROP_WHITENESS);
    assign op_inv   = (raster_op == ROP_DSTINVERT);
    assign blit_copy = cmd_blit && !op_black && !op_white && !op_inv;
    assign op_low   = raster_op[7:0];

    always_comb
    begin
        dec_rmw   = 1'b0;
        dec_inv   = 1'b0;
        dec_value = fill_color;
        if (cmd_blit)
        begin
            dec_value = op_white ? WHITE_INDEX : '0;
            dec_rmw   = op_inv;
            dec_inv   = op_inv;
        end
        else
        begin
            case (op_low)
                FILL_BLACK: dec_value = '0;
                FILL_WHITE: dec_value = WHITE_INDEX;
                FILL_COLOR: dec_value = fill_color;
                FILL_XOR:   dec_rmw   = 1'b1;
                default:    dec_value = fill_color;
            endcase
        end
    end

    // rectangle clipping
    logic signed [CW-1:0] sx, sy, xe, ye, x0, y0, x1, y1, x_last, y_last;

    assign sx = CW'(pos_x);
    assign sy = CW'(pos_y);
    assign xe = sx + $signed({2'b00, rect_width});
    assign ye = sy + $signed({2'b00, rect_height});
    assign x0 = sx[CW-1] ? '0 : sx;
    assign y0 = sy[CW-1] ? '0 : sy;
    assign x1 = (xe > SW_S) ? SW_S : xe;
    assign y1 = (ye > SH_S) ? SH_S : ye;
    assign x_last = x1 - CW'(1);
    assign y_last = y1 - CW'(1);

    logic rd_on;
    assign rd_on = !sx[CW-1] && (sx < SW_S) && !sy[CW-1] && (sy < SH_S);

    // copy state
    logic signed [POS_W-1:0] copy_ox_reg, copy_oy_reg;
    logic [RECT_W-1:0]       copy_w_reg, copy_h_reg, copy_col_reg, copy_row_reg;
    logic                    copy_pending_reg;
    logic signed [CW-1:0]    cx, cy;
    logic                    c_on;
    logic [RECT_W:0]         col_inc, row_inc;

    assign cx = CW'(copy_ox_reg) + $signed({2'b00, copy_col_reg});
    assign cy = CW'(copy_oy_reg) + $signed({2'b00, copy_row_reg});
    assign c_on = !cx[CW-1] && (cx < SW_S) && !cy[CW-1] && (cy < SH_S);
    assign col_inc = {1'b0, copy_col_reg} + (RECT_W+1)'(1);
    assign row_inc = {1'b0, copy_row_reg} + (RECT_W+1)'(1);

    // paint walker
    logic [XW-1:0]    px_reg, x_first_reg, x_last_reg;
    logic [YW-1:0]    py_reg, y_last_reg;
    logic             rmw_reg, inv_reg;
    logic [PIX_W-1:0] value_reg;

    // misc
    logic             graphics_mode_reg;
    logic [AW-1:0]    clr_cnt_reg;
    logic             rd_gate_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] pixel_value_reg;

    // frame port
    logic             painting;
    logic [XW-1:0]    col_sel;
    logic [YW-1:0]    row_sel;
    logic [AW-1:0]    mem_addr;
    logic             mem_we, mem_re, src_we;
    logic [PIX_W-1:0] mem_wdata, mem_rdata, old_pix, paint_pix;

    assign painting = ctrl.paint_we || ctrl.paint_re;
    assign src_we   = ctrl.accept && cmd_src && copy_pending_reg && c_on;

    always_comb
    begin
        if (painting)
        begin
            col_sel = px_reg;
            row_sel = py_reg;
        end
        else if (cmd_src)
        begin
            col_sel = cx[XW-1:0];
            row_sel = cy[YW-1:0];
        end
        else
        begin
            col_sel = sx[XW-1:0];
            row_sel = sy[YW-1:0];
        end
    end

    assign old_pix   = graphics_mode_reg ? mem_rdata : '0;
    assign paint_pix = !rmw_reg ? value_reg : (inv_reg ? ~old_pix : (old_pix ^ value_reg));

    always_comb
    begin
        if (ctrl.clr_we)
        begin
            mem_addr  = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_addr  = AW'(row_sel) * AW'(SCREEN_WIDTH) + AW'(col_sel);
            mem_wdata = painting ? paint_pix : source_pixel;
        end
    end

    assign mem_we = ctrl.clr_we || ctrl.paint_we || src_we;
    assign mem_re = ctrl.paint_re || (ctrl.accept && cmd_read);

    rob_frame_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign stat.clr_last   = (clr_cnt_reg == LAST_ADDR);
    assign stat.dec_read   = cmd_read;
    assign stat.dec_paint  = (cmd_fill || (cmd_blit && !blit_copy))
                             && (x0 < x1) && (y0 < y1);
    assign stat.dec_rmw    = dec_rmw;
    assign stat.paint_last = (px_reg == x_last_reg) && (py_reg == y_last_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign pixel_value = pixel_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            graphics_mode_reg <= 1'b0;
            clr_cnt_reg       <= '0;
            copy_ox_reg       <= '0;
            copy_oy_reg       <= '0;
            copy_w_reg        <= '0;
            copy_h_reg        <= '0;
            copy_col_reg      <= '0;
            copy_row_reg      <= '0;
            copy_pending_reg  <= 1'b0;
            out_valid_reg     <= 1'b0;
            rd_gate_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                graphics_mode_reg <= cfg_data;
            end
            if (ctrl.clr_we)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (ctrl.accept)
            begin
                if (cmd_src)
                begin
                    if (copy_pending_reg)
                    begin
                        if (col_inc >= {1'b0, copy_w_reg})
                        begin
                            copy_col_reg <= '0;
                            if (row_inc >= {1'b0, copy_h_reg})
                            begin
                                copy_row_reg     <= '0;
                                copy_pending_reg <= 1'b0;
                            end
                            else
                            begin
                                copy_row_reg <= row_inc[RECT_W-1:0];
                            end
                        end
                        else
                        begin
                            copy_col_reg <= col_inc[RECT_W-1:0];
                        end
                    end
                end
                else
                begin
                    copy_pending_reg <= 1'b0;
                    if (blit_copy && (rect_width != '0) && (rect_height != '0))
                    begin
                        copy_ox_reg      <= pos_x;
                        copy_oy_reg      <= pos_y;
                        copy_w_reg       <= rect_width;
                        copy_h_reg       <= rect_height;
                        copy_col_reg     <= '0;
                        copy_row_reg     <= '0;
                        copy_pending_reg <= 1'b1;
                    end
                end
                if (cmd_read)
                begin
                    rd_gate_reg <= rd_on && graphics_mode_reg;
                end
            end
            if (ctrl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept && !cmd_src && !cmd_read)
        begin
            px_reg      <= x0[XW-1:0];
            py_reg      <= y0[YW-1:0];
            x_first_reg <= x0[XW-1:0];
            x_last_reg  <= x_last[XW-1:0];
            y_last_reg  <= y_last[YW-1:0];
            rmw_reg     <= dec_rmw;
            inv_reg     <= dec_inv;
            value_reg   <= dec_value;
        end
        else if (ctrl.paint_we)
        begin
            if (px_reg == x_last_reg)
            begin
                px_reg <= x_first_reg;
                py_reg <= py_reg + YW'(1);
            end
            else
            begin
                px_reg <= px_reg + XW'(1);
            end
        end
        if (ctrl.out_load)
        begin
            pixel_value_reg <= rd_gate_reg ? mem_rdata : '0;
        end
    end

endmodule

>>> rtl/raster_op_blitter.sv
// 2D blitter over an on-chip SCREEN_WIDTH x SCREEN_HEIGHT 8-bit frame store with one
// single-port RAM. After reset the block clears all SCREEN_WIDTH*SCREEN_HEIGHT pixels
// (64000 at the default size) one pixel per cycle, with in_ready low; cfg writes are
// taken at any time. Source-pixel beats, copy setup, empty rectangles and stray source
// pixels do not leave the idle state. A read waits for the result slot; a solid or
// constant fill writes each clipped pixel once; an XOR fill or destination invert
// reads, then writes each clipped pixel on the same RAM port.
module raster_op_blitter #(
    parameter int SCREEN_WIDTH  = rob_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = rob_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rob_pkg::CMD_W-1:0]         command,
    input  logic signed [rob_pkg::POS_W-1:0]  pos_x,
    input  logic signed [rob_pkg::POS_W-1:0]  pos_y,
    input  logic [rob_pkg::RECT_W-1:0]        rect_width,
    input  logic [rob_pkg::RECT_W-1:0]        rect_height,
    input  logic [rob_pkg::PIX_W-1:0]         fill_color,
    input  logic [rob_pkg::ROP_W-1:0]         raster_op,
    input  logic [rob_pkg::PIX_W-1:0]         source_pixel,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rob_pkg::PIX_W-1:0]         pixel_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data
);
    import rob_pkg::*;

    rob_ctrl_t ctrl;
    rob_stat_t stat;

    rob_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    rob_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .command      (command),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .rect_width   (rect_width),
        .rect_height  (rect_height),
        .fill_color   (fill_color),
        .raster_op    (raster_op),
        .source_pixel (source_pixel),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_value  (pixel_value)
    );

    // at most one RAM operation kind per cycle from the sequencer
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.clr_we, ctrl.paint_re, ctrl.paint_we, ctrl.out_load}))
        else $error("conflicting frame port commands");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> stat.out_free)
        else $error("result loaded over an unread beat");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && stat.dec_read) |=> !in_ready)
        else $error("input taken while a read is in flight");

    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clr_we |-> (!in_ready && !ctrl.accept))
        else $error("input taken during frame clear");

endmodule

>>> dv/raster_op_blitter_tb.sv
`timescale 1ns / 100ps

module raster_op_blitter_tb;
    import rob_pkg::*;

    localparam int SCR_W       = DEF_SCREEN_WIDTH;
    localparam int SCR_H       = DEF_SCREEN_HEIGHT;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam logic [ROP_W-1:0] ROP_SRCCOPY = 32'h00CC_0020;

    typedef enum {PAINT_SET, PAINT_XOR, PAINT_INV} paint_mode_t;

    typedef struct {
        rob_cmd_code_t           cmd;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [RECT_W-1:0]       w;
        logic [RECT_W-1:0]       h;
        logic [PIX_W-1:0]        color;
        logic [ROP_W-1:0]        rop;
        logic [PIX_W-1:0]        src;
    } blit_cmd_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [CMD_W-1:0]         command = '0;
    logic signed [POS_W-1:0]  pos_x = '0;
    logic signed [POS_W-1:0]  pos_y = '0;
    logic [RECT_W-1:0]        rect_width = '0;
    logic [RECT_W-1:0]        rect_height = '0;
    logic [PIX_W-1:0]         fill_color = '0;
    logic [ROP_W-1:0]         raster_op = '0;
    logic [PIX_W-1:0]         source_pixel = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [PIX_W-1:0]         pixel_value;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic                     cfg_data = 1'b0;

    // predicted frame store and copy state
    logic [PIX_W-1:0] frame_px [SCR_W*SCR_H];
    bit               gfx_on = 1'b0;
    bit               cp_busy = 1'b0;
    int               cp_x, cp_y, cp_w, cp_h, cp_col, cp_row;
    logic [PIX_W-1:0] read_values_due [$];

    blit_cmd_t        cmd_queue [$];
    blit_cmd_t        on_bus;
    int               items_queued = 0;
    int               in_sent = 0;
    int               in_beats = 0;
    int               errors = 0;
    int               cycles = 0;
    int               episode_no = 0;
    int               hot_x = 0;
    int               hot_y = 0;
    bit               calm = 1'b0;

    raster_op_blitter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .rect_width   (rect_width),
        .rect_height  (rect_height),
        .fill_color   (fill_color),
        .raster_op    (raster_op),
        .source_pixel (source_pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_value  (pixel_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [PIX_W-1:0] px_read(int x, int y);
        if (!gfx_on || x < 0 || x >= SCR_W || y < 0 || y >= SCR_H)
            return '0;
        return frame_px[y*SCR_W + x];
    endfunction

    function automatic void px_write(int x, int y, logic [PIX_W-1:0] v);
        if (x >= 0 && x < SCR_W && y >= 0 && y < SCR_H)
            frame_px[y*SCR_W + x] = v;
    endfunction

    function automatic void paint_box(int x, int y, int w, int h,
                                      paint_mode_t mode, logic [PIX_W-1:0] v);
        int x0, y0, x1, y1;
        logic [PIX_W-1:0] old;
        x0 = (x < 0) ? 0 : x;
        y0 = (y < 0) ? 0 : y;
        x1 = (x + w > SCR_W) ? SCR_W : x + w;
        y1 = (y + h > SCR_H) ? SCR_H : y + h;
        for (int py = y0; py < y1; py++)
            for (int px = x0; px < x1; px++)
            begin
                old = px_read(px, py);
                case (mode)
                    PAINT_XOR: px_write(px, py, old ^ v);
                    PAINT_INV: px_write(px, py, ~old);
                    default:   px_write(px, py, v);
                endcase
            end
    endfunction

    function automatic void fill_rect(int x, int y, int w, int h,
                                      logic [PIX_W-1:0] color, logic [7:0] op_lo);
        case (op_lo)
            FILL_BLACK: paint_box(x, y, w, h, PAINT_SET, '0);
            FILL_WHITE: paint_box(x, y, w, h, PAINT_SET, WHITE_INDEX);
            FILL_XOR:   paint_box(x, y, w, h, PAINT_XOR, color);
            default:    paint_box(x, y, w, h, PAINT_SET, color);
        endcase
    endfunction

    // updates the predicted frame for one accepted command
    function automatic void apply_cmd(blit_cmd_t c);
        int x, y, w, h;
        x = c.x;
        y = c.y;
        w = c.w;
        h = c.h;
        if (c.cmd == CMD_SOURCE)
        begin
            if (cp_busy)
            begin
                px_write(cp_x + cp_col, cp_y + cp_row, c.src);
                cp_col++;
                if (cp_col >= cp_w)
                begin
                    cp_col = 0;
                    cp_row++;
                    if (cp_row >= cp_h)
                    begin
                        cp_row = 0;
                        cp_busy = 1'b0;
                    end
                end
            end
            return;
        end
        cp_busy = 1'b0;
        case (c.cmd)
            CMD_READ: read_values_due.push_back(px_read(x, y));
            CMD_FILL: fill_rect(x, y, w, h, c.color, c.rop[7:0]);
            default:
            begin
                if (c.rop == ROP_BLACKNESS || c.rop == ROP_WHITENESS)
                    fill_rect(x, y, w, h, '0, c.rop[7:0]);
                else if (c.rop == ROP_DSTINVERT)
                    paint_box(x, y, w, h, PAINT_INV, '0);
                else if (w > 0 && h > 0)
                begin
                    cp_x = x;
                    cp_y = y;
                    cp_w = w;
                    cp_h = h;
                    cp_col = 0;
                    cp_row = 0;
                    cp_busy = 1'b1;
                end
            end
        endcase
    endfunction

    // driver: one item on the bus at a time, random gaps unless calm
    always @(negedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 10);
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_beats == in_sent)
        begin
            if (cmd_queue.size() != 0 && (calm || $urandom_range(99) >= 10))
            begin
                on_bus = cmd_queue.pop_front();
                in_sent++;
                in_valid     <= 1'b1;
                command      <= on_bus.cmd;
                pos_x        <= on_bus.x;
                pos_y        <= on_bus.y;
                rect_width   <= on_bus.w;
                rect_height  <= on_bus.h;
                fill_color   <= on_bus.color;
                raster_op    <= on_bus.rop;
                source_pixel <= on_bus.src;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: predict on input beats, check result beats
    always @(posedge clk)
    begin : monitor
        logic [PIX_W-1:0] want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                apply_cmd(on_bus);
                in_beats++;
            end
            if (out_valid && out_ready)
            begin
                if (read_values_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected pixel_value: expected none, actual %02h",
                             $time, pixel_value);
                end
                else
                begin
                    want = read_values_due.pop_front();
                    if (pixel_value !== want)
                    begin
                        errors++;
                        $display("%0t: pixel_value mismatch: expected %02h, actual %02h",
                                 $time, want, pixel_value);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("raster_op_blitter test failed");
            $finish;
        end
    end

    task automatic push(blit_cmd_t c);
        cmd_queue.push_back(c);
        items_queued++;
    endtask

    function automatic blit_cmd_t with_box(blit_cmd_t c, int x, int y, int w, int h);
        c.x = POS_W'(x);
        c.y = POS_W'(y);
        c.w = RECT_W'(w);
        c.h = RECT_W'(h);
        return c;
    endfunction

    function automatic blit_cmd_t cmd_of(rob_cmd_code_t op, int x, int y, int w, int h,
                                         int color, logic [ROP_W-1:0] rop, int src);
        blit_cmd_t c;
        c.cmd = op;
        c.color = PIX_W'(color);
        c.rop = rop;
        c.src = PIX_W'(src);
        return with_box(c, x, y, w, h);
    endfunction

    function automatic blit_cmd_t rand_cmd(rob_cmd_code_t op);
        blit_cmd_t c;
        c.cmd = op;
        c.x = POS_W'($urandom);
        c.y = POS_W'($urandom);
        c.w = RECT_W'($urandom);
        c.h = RECT_W'($urandom);
        c.color = PIX_W'($urandom);
        c.rop = $urandom;
        c.src = PIX_W'($urandom);
        return c;
    endfunction

    function automatic logic [ROP_W-1:0] fill_op();
        logic [ROP_W-1:0] r;
        r = $urandom;
        case ($urandom_range(4))
            0: r[7:0] = FILL_BLACK;
            1: r[7:0] = FILL_WHITE;
            2: r[7:0] = FILL_COLOR;
            3: r[7:0] = FILL_XOR;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [ROP_W-1:0] paint_rop();
        case ($urandom_range(2))
            0: return ROP_BLACKNESS;
            1: return ROP_WHITENESS;
            default: return ROP_DSTINVERT;
        endcase
    endfunction

    // mostly near the origin or the far corner so that reads hit painted pixels
    task automatic pick_spot(output int x, output int y);
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                x = int'($urandom_range(30)) - 6;
                y = int'($urandom_range(30)) - 6;
            end
            4, 5:
            begin
                x = 300 + $urandom_range(25);
                y = 185 + $urandom_range(20);
            end
            6, 7, 8:
            begin
                x = $urandom_range(SCR_W - 1);
                y = $urandom_range(SCR_H - 1);
            end
            default:
            begin
                x = int'($urandom_range(2047)) - 1024;
                y = int'($urandom_range(2047)) - 1024;
            end
        endcase
    endtask

    // n: items pushed that the block acts on
    task automatic random_episode(output int n);
        blit_cmd_t c;
        int x, y, k, pick;
        pick = $urandom_range(99);
        episode_no++;
        pick_spot(x, y);
        n = 1;
        if (episode_no % 120 == 60)
        begin
            // full-range rectangle, clipped by the screen
            if ($urandom_range(1))
            begin
                c = rand_cmd(CMD_FILL);
                c.rop = fill_op();
            end
            else
            begin
                c = rand_cmd(CMD_BLIT);
                c.rop = paint_rop();
            end
            push(with_box(c, x, y, c.w, c.h));
        end
        else if (pick < 30)
        begin
            c = rand_cmd(CMD_BLIT);
            c.rop = $urandom_range(1) ? ROP_SRCCOPY : $urandom;
            c = with_box(c, x, y, $urandom_range(1, 5), $urandom_range(1, 5));
            push(c);
            hot_x = x;
            hot_y = y;
            k = c.w * c.h;
            pick = $urandom_range(99);
            if (pick < 12)
                k = $urandom_range(k - 1);
            else if (pick < 20)
                k += $urandom_range(1, 2);
            repeat (k) push(rand_cmd(CMD_SOURCE));
            n = 1 + k;
        end
        else if (pick < 50)
        begin
            c = rand_cmd(CMD_FILL);
            c.rop = fill_op();
            push(with_box(c, x, y, $urandom_range(8), $urandom_range(8)));
            hot_x = x;
            hot_y = y;
        end
        else if (pick < 60)
        begin
            c = rand_cmd(CMD_BLIT);
            c.rop = paint_rop();
            push(with_box(c, x, y, $urandom_range(8), $urandom_range(8)));
            hot_x = x;
            hot_y = y;
        end
        else if (pick < 90)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                c = rand_cmd(CMD_READ);
                if ($urandom_range(1))
                begin
                    x = hot_x + int'($urandom_range(7)) - 1;
                    y = hot_y + int'($urandom_range(7)) - 1;
                end
                else
                    pick_spot(x, y);
                push(with_box(c, x, y, c.w, c.h));
            end
        end
        else if (pick < 95)
        begin
            // stray beat, normally ignored
            push(rand_cmd(CMD_SOURCE));
            n = 0;
        end
        else
        begin
            // copy of random size, abandoned by whatever comes next
            c = rand_cmd(CMD_BLIT);
            c.rop = $urandom_range(1) ? ROP_SRCCOPY : $urandom;
            push(with_box(c, x, y, c.w, c.h));
            k = $urandom_range(3);
            repeat (k) push(rand_cmd(CMD_SOURCE));
            n = 1 + k;
        end
    endtask

    // a trailing read flushes the pipeline; its result means the block is idle
    task automatic drain();
        int x, y;
        pick_spot(x, y);
        push(cmd_of(CMD_READ, x, y, 0, 0, 0, '0, 0));
        while (in_beats != items_queued || read_values_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_random(int count);
        int done, n;
        done = 0;
        while (done < count)
        begin
            random_episode(n);
            done += n;
        end
        drain();
    endtask

    task automatic write_mode(bit v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        gfx_on = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        foreach (frame_px[i]) frame_px[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_mode(1'b1);
        push(cmd_of(CMD_READ, 0, 0, 0, 0, 0, '0, 0));
        push(cmd_of(CMD_FILL, -5, -3, 10, 8, 8'hA5, {24'h0, FILL_COLOR}, 0));
        push(cmd_of(CMD_READ, 4, 4, 0, 0, 0, '0, 0));
        push(cmd_of(CMD_FILL, 3, 3, 4, 4, 8'h3C, {24'hFF_FFFF, FILL_XOR}, 255));
        push(cmd_of(CMD_READ, 4, 4, 1023, 1023, 255, 32'hFFFF_FFFF, 255));
        push(cmd_of(CMD_FILL, 316, 196, 3, 3, 0, {24'h0, FILL_WHITE}, 0));
        push(cmd_of(CMD_FILL, 318, 198, 1023, 1023, 255, {24'h12_3456, FILL_BLACK}, 0));
        push(cmd_of(CMD_READ, 317, 197, 0, 0, 0, '0, 0));
        push(cmd_of(CMD_FILL, 10, 10, 2, 2, 8'h5A, 32'h0000_0077, 0));
        // empty and fully off-screen rectangles
        push(cmd_of(CMD_FILL, 0, 0, 0, 1023, 255, {24'h0, FILL_COLOR}, 0));
        push(cmd_of(CMD_FILL, -1024, -1024, 1023, 1023, 255, {24'h0, FILL_COLOR}, 0));
        push(cmd_of(CMD_BLIT, 0, 0, 2, 2, 255, ROP_BLACKNESS, 0));
        push(cmd_of(CMD_BLIT, 2, 0, 2, 1, 0, ROP_WHITENESS, 0));
        push(cmd_of(CMD_BLIT, 0, 0, 5, 1, 0, ROP_DSTINVERT, 0));
        push(cmd_of(CMD_READ, 3, 0, 0, 0, 0, '0, 0));
        // copy hanging off the bottom right corner
        push(cmd_of(CMD_BLIT, 319, 199, 2, 2, 0, ROP_SRCCOPY, 0));
        push(cmd_of(CMD_SOURCE, 0, 0, 0, 0, 0, '0, 8'h11));
        push(cmd_of(CMD_SOURCE, 0, 0, 0, 0, 0, '0, 0));
        push(cmd_of(CMD_SOURCE, 0, 0, 0, 0, 0, '0, 255));
        push(cmd_of(CMD_SOURCE, 0, 0, 0, 0, 0, '0, 8'h44));
        push(cmd_of(CMD_READ, 319, 199, 0, 0, 0, '0, 0));
        // copy cut short by a read, then a stray beat
        push(cmd_of(CMD_BLIT, 20, 20, 3, 3, 0, 32'hFFFF_FFFF, 0));
        push(cmd_of(CMD_SOURCE, 0, 0, 0, 0, 0, '0, 8'h80));
        push(cmd_of(CMD_SOURCE, 0, 0, 0, 0, 0, '0, 8'h81));
        push(cmd_of(CMD_READ, 21, 20, 0, 0, 0, '0, 0));
        push(cmd_of(CMD_SOURCE, 22, 20, 0, 0, 0, '0, 8'h99));
        push(cmd_of(CMD_BLIT, 30, 30, 0, 1023, 0, ROP_SRCCOPY, 0));
        push(cmd_of(CMD_SOURCE, 30, 30, 0, 0, 0, '0, 8'h77));
        push(cmd_of(CMD_READ, -1024, -1024, 0, 0, 0, '0, 0));
        push(cmd_of(CMD_READ, 1023, 1023, 0, 0, 0, '0, 0));
        drain();

        // graphics mode off: old pixels read as zero
        write_mode(1'b0);
        push(cmd_of(CMD_BLIT, 0, 0, 1023, 1023, 0, ROP_DSTINVERT, 0));
        push(cmd_of(CMD_FILL, 5, 5, 3, 3, 8'h66, {24'h0, FILL_XOR}, 0));
        run_random(250);

        write_mode(1'b1);
        run_random(650);
        calm = 1'b1;
        run_random(300);
        calm = 1'b0;

        write_mode(1'b0);
        run_random(200);

        repeat (16) @(posedge clk);
        if (errors == 0 && read_values_due.size() == 0)
            $display("raster_op_blitter test passed");
        else
            $display("raster_op_blitter test failed");
        $finish;
    end

endmodule
